// ===== rtl/core/adsr_pkg.sv =====
// Shared types, codes and constants for the ADSR envelope bank.
// No dependencies; imported by every module under rtl/core.
package adsr_pkg;

    // Default number of voices
    localparam int VOICES_DEF = 8;

    // Fixed field widths
    localparam int TIME_W  = 24;   // Q8.16 seconds, voice state
    localparam int VAL_W   = 16;   // Q0.16 times and Q1.15 levels
    localparam int DIV_BITS = 16;  // quotient bits per division

    localparam logic [TIME_W-1:0] TIME_MAX  = 24'hFF_FFFF;
    localparam logic [VAL_W-1:0]  LEVEL_ONE = 16'd32768;

    // Register reset values
    localparam logic [VAL_W-1:0] ATTACK_LEVEL_RST  = 16'd19661;
    localparam logic [VAL_W-1:0] ATTACK_TIME_RST   = 16'd6554;
    localparam logic [VAL_W-1:0] DECAY_TIME_RST    = 16'd13107;
    localparam logic [VAL_W-1:0] SUSTAIN_LEVEL_RST = 16'd13107;
    localparam logic [VAL_W-1:0] RELEASE_TIME_RST  = 16'd6554;

    // Register indexes
    localparam logic [2:0] CFG_ATTACK_LEVEL  = 3'd0;
    localparam logic [2:0] CFG_ATTACK_TIME   = 3'd1;
    localparam logic [2:0] CFG_DECAY_TIME    = 3'd2;
    localparam logic [2:0] CFG_SUSTAIN_LEVEL = 3'd3;
    localparam logic [2:0] CFG_RELEASE_TIME  = 3'd4;

    // Request codes
    localparam logic [1:0] REQ_TICK    = 2'd0;
    localparam logic [1:0] REQ_PRESS   = 2'd1;
    localparam logic [1:0] REQ_RELEASE = 2'd2;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [2:0]       voice_sel;
        logic [VAL_W-1:0] time_step;
    } cmd_t;

    typedef struct packed {
        logic [2:0]       voice_id;
        logic [VAL_W-1:0] amplitude;
        logic [18:0]      volume;
        logic             last_voice;
    } result_t;

    typedef struct packed {
        logic [VAL_W-1:0] attack_level;
        logic [VAL_W-1:0] attack_time;
        logic [VAL_W-1:0] decay_time;
        logic [VAL_W-1:0] sustain_level;
        logic [VAL_W-1:0] release_time;
    } cfg_t;

    // One voice's entry in the state memory
    typedef struct packed {
        logic [TIME_W-1:0] elapsed;
        logic              held;
        logic [TIME_W-1:0] release_at;
    } voice_word_t;

    // How the level of the current voice is formed
    typedef enum logic [1:0] {
        LVL_ZERO = 2'd0,   // silent
        LVL_HOLD = 2'd1,   // base level as it stands
        LVL_RISE = 2'd2,   // base plus quotient
        LVL_FALL = 2'd3    // base minus quotient
    } lvl_mode_t;

endpackage

// ===== rtl/core/adsr_state_mem.sv =====
// Voice state memory: one write port, one read port, registered read data.
// Depends on adsr_pkg for the entry type.
module adsr_state_mem
    import adsr_pkg::*;
#(
    parameter int VOICES = VOICES_DEF,
    localparam int AW = (VOICES > 1) ? $clog2(VOICES) : 1
)
(
    input  logic        clk,
    input  logic        rd_en,
    input  logic [AW-1:0] rd_addr,
    output voice_word_t rd_data,
    input  logic        wr_en,
    input  logic [AW-1:0] wr_addr,
    input  voice_word_t wr_data
);

    voice_word_t mem_reg [VOICES];
    voice_word_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/adsr_div.sv =====
// Restoring divider, one quotient bit per cycle; numerator below den * 2^16.
// Depends on adsr_pkg for widths.
module adsr_div
    import adsr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [2*VAL_W-1:0]   num,
    input  logic [VAL_W-1:0]     den,
    output logic                 done,
    output logic [VAL_W-1:0]     quo
);

    localparam int CW = $clog2(DIV_BITS + 1);

    logic [CW-1:0]    cnt_reg;
    logic             done_reg;
    logic [VAL_W-1:0] rem_reg, rem_next;
    logic [VAL_W-1:0] quo_reg, quo_next;
    logic [VAL_W:0]   trial;
    logic [VAL_W:0]   diff;

    always_comb
    begin
        trial = {rem_reg, quo_reg[VAL_W-1]};
        diff  = trial - {1'b0, den};
        if (trial >= {1'b0, den})
        begin
            rem_next = diff[VAL_W-1:0];
            quo_next = {quo_reg[VAL_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[VAL_W-1:0];
            quo_next = {quo_reg[VAL_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CW'(DIV_BITS);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == CW'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num[2*VAL_W-1:VAL_W];
            quo_reg <= num[VAL_W-1:0];
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== rtl/core/adsr_seq.sv =====
// Request sequencer: read-modify-write of voice state, level evaluation per voice.
// Depends on adsr_pkg; drives adsr_state_mem and adsr_div.
module adsr_seq
    import adsr_pkg::*;
#(
    parameter int VOICES = VOICES_DEF,
    localparam int AW = (VOICES > 1) ? $clog2(VOICES) : 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  cmd_t          cmd,
    input  cfg_t          cfg,
    output logic          result_valid,
    output result_t       result,
    output logic          rd_en,
    output logic [AW-1:0] rd_addr,
    input  voice_word_t   rd_data,
    output logic          wr_en,
    output logic [AW-1:0] wr_addr,
    output voice_word_t   wr_data,
    output logic          div_start,
    output logic [2*VAL_W-1:0] div_num,
    output logic [VAL_W-1:0]   div_den,
    input  logic          div_done,
    input  logic [VAL_W-1:0]   div_quo
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_RD    = 8'b0000_0010,
        S_MOD   = 8'b0000_0100,
        S_PHASE = 8'b0000_1000,
        S_MUL   = 8'b0001_0000,
        S_DIVS  = 8'b0010_0000,
        S_DIVW  = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic [AW-1:0]      cnt_reg, cnt_next;
    logic [1:0]         kind_reg, kind_next;
    logic [VAL_W-1:0]   step_reg, step_next;
    logic [VOICES-1:0]  pressed_reg, pressed_next;
    logic [TIME_W-1:0]  t_reg, t_next;
    lvl_mode_t          mode_reg, mode_next;
    logic [VAL_W-1:0]   base_reg, base_next;
    logic [VAL_W-1:0]   mx_reg, mx_next;
    logic [VAL_W-1:0]   mu_reg, mu_next;
    logic [VAL_W-1:0]   md_reg, md_next;
    logic [2*VAL_W-1:0] prod_reg;
    result_t            result_reg, result_next;
    logic               result_valid_reg, result_valid_next;

    logic               sel_ok;
    logic               last;
    logic [TIME_W:0]    e_sum;
    logic [TIME_W-1:0]  e_sat;
    logic [TIME_W:0]    ad_end;
    logic [TIME_W-1:0]  u_rel;
    logic [VAL_W:0]     amp_wide;
    logic [VAL_W-1:0]   amp;

    always_comb
    begin
        sel_ok = ({4'b0, cmd.voice_sel} < 7'(VOICES));
        last   = (cnt_reg == AW'(VOICES - 1));
        e_sum  = {1'b0, rd_data.elapsed} + (TIME_W + 1)'(step_reg);
        e_sat  = e_sum[TIME_W] ? TIME_MAX : e_sum[TIME_W-1:0];
        ad_end = (TIME_W + 1)'(cfg.attack_time) + (TIME_W + 1)'(cfg.decay_time);
        u_rel  = (t_reg >= rd_data.release_at) ? (t_reg - rd_data.release_at) : '0;

        case (mode_reg)
            LVL_HOLD: amp_wide = {1'b0, base_reg};
            LVL_RISE: amp_wide = {1'b0, base_reg} + {1'b0, div_quo};
            LVL_FALL: amp_wide = {1'b0, base_reg - div_quo};
            default:  amp_wide = '0;
        endcase
        amp = (amp_wide > (VAL_W + 1)'(LEVEL_ONE)) ? LEVEL_ONE : amp_wide[VAL_W-1:0];
    end

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        kind_next         = kind_reg;
        step_next         = step_reg;
        pressed_next      = pressed_reg;
        t_next            = t_reg;
        mode_next         = mode_reg;
        base_next         = base_reg;
        mx_next           = mx_reg;
        mu_next           = mu_reg;
        md_next           = md_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;
        rd_en             = 1'b0;
        wr_en             = 1'b0;
        wr_data           = rd_data;
        div_start         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next = cmd.req_type;
                    step_next = cmd.time_step;
                    case (cmd.req_type)
                        REQ_TICK:
                        begin
                            cnt_next   = '0;
                            state_next = S_RD;
                        end
                        REQ_PRESS, REQ_RELEASE:
                        begin
                            if (sel_ok)
                            begin
                                cnt_next   = AW'(cmd.voice_sel);
                                state_next = S_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_MOD;
            end

            S_MOD:
            begin
                case (kind_reg)
                    REQ_PRESS:
                    begin
                        wr_en                 = 1'b1;
                        wr_data.elapsed       = '0;
                        wr_data.held          = 1'b1;
                        pressed_next[cnt_reg] = 1'b1;
                        state_next            = S_IDLE;
                    end
                    REQ_RELEASE:
                    begin
                        // ignored for a voice never pressed
                        wr_en              = pressed_reg[cnt_reg];
                        wr_data.held       = 1'b0;
                        wr_data.release_at = rd_data.elapsed;
                        state_next         = S_IDLE;
                    end
                    default:
                    begin
                        wr_en           = 1'b1;
                        wr_data.elapsed = e_sat;
                        t_next          = e_sat;
                        state_next      = S_PHASE;
                    end
                endcase
            end

            S_PHASE:
            begin
                base_next  = cfg.sustain_level;
                mode_next  = LVL_HOLD;
                state_next = S_FIN;
                if (!pressed_reg[cnt_reg])
                begin
                    mode_next = LVL_ZERO;
                end
                else if (rd_data.held)
                begin
                    if (t_reg < TIME_W'(cfg.attack_time))
                    begin
                        // attack: rise from zero
                        mode_next  = LVL_RISE;
                        base_next  = '0;
                        mx_next    = cfg.attack_level;
                        mu_next    = t_reg[VAL_W-1:0];
                        md_next    = cfg.attack_time;
                        state_next = S_MUL;
                    end
                    else if ({1'b0, t_reg} < ad_end)
                    begin
                        // decay: move from attack level towards sustain
                        base_next  = cfg.attack_level;
                        mu_next    = VAL_W'(t_reg - TIME_W'(cfg.attack_time));
                        md_next    = cfg.decay_time;
                        state_next = S_MUL;
                        if (cfg.sustain_level >= cfg.attack_level)
                        begin
                            mode_next = LVL_RISE;
                            mx_next   = cfg.sustain_level - cfg.attack_level;
                        end
                        else
                        begin
                            mode_next = LVL_FALL;
                            mx_next   = cfg.attack_level - cfg.sustain_level;
                        end
                    end
                end
                else if (cfg.release_time == '0 || u_rel >= TIME_W'(cfg.release_time))
                begin
                    mode_next = LVL_ZERO;
                end
                else
                begin
                    // release: fall from sustain level
                    mode_next  = LVL_FALL;
                    mx_next    = cfg.sustain_level;
                    mu_next    = u_rel[VAL_W-1:0];
                    md_next    = cfg.release_time;
                    state_next = S_MUL;
                end
            end

            S_MUL:
            begin
                state_next = S_DIVS;
            end

            S_DIVS:
            begin
                div_start  = 1'b1;
                state_next = S_DIVW;
            end

            S_DIVW:
            begin
                if (div_done)
                begin
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                result_valid_next      = 1'b1;
                result_next.voice_id   = 3'(cnt_reg);
                result_next.amplitude  = amp;
                result_next.volume     = {amp, 3'b000};
                result_next.last_voice = last;
                if (last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_RD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            pressed_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            pressed_reg      <= pressed_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        kind_reg   <= kind_next;
        step_reg   <= step_next;
        t_reg      <= t_next;
        mode_reg   <= mode_next;
        base_reg   <= base_next;
        mx_reg     <= mx_next;
        mu_reg     <= mu_next;
        md_reg     <= md_next;
        result_reg <= result_next;
        if (state_reg == S_MUL)
        begin
            prod_reg <= mx_reg * mu_reg;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign rd_addr      = cnt_reg;
    assign wr_addr      = cnt_reg;
    assign div_num      = prod_reg;
    assign div_den      = md_reg;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== rtl/core/adsr_envelope_bank_top.sv =====
// Top level of the ADSR envelope bank: configuration registers and block wiring.
// Depends on adsr_pkg, adsr_state_mem, adsr_div and adsr_seq.
//
// A bank of VOICES linear ADSR envelopes. A transaction is taken when start is
// high and busy is low; a press or release for a voice outside the bank, and an
// unknown request code, is taken and dropped. Press and release read the
// voice's state, write it back and return to idle. A tick walks the voices
// in order, reading each one's state from a one-port-read memory, saturating
// its elapsed time and writing it back, then forming its level. Ramps need one
// 16 x 16 product and a restoring division in the divider that all voices
// share, so a voice in attack, decay or release passes through both, while a
// voice that is silent or sustaining skips them and goes straight to its result.
// Each result appears on result for exactly one cycle with result_valid high;
// the receiver cannot stall it, so it must take every strobe. The last result
// of a tick carries last_voice. Configuration writes via cfg_we, cfg_index and
// cfg_data take effect at once and should only be made while busy is low.
// Per-voice "ever pressed" flags sit in flip-flops cleared by reset, so the
// memory needs no clearing pass and the block is ready straight after reset.
module adsr_envelope_bank_top
    import adsr_pkg::*;
#(
    parameter int VOICES = VOICES_DEF,
    localparam int AW = (VOICES > 1) ? $clog2(VOICES) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  cmd_t             cmd,
    output logic             result_valid,
    output result_t          result,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [VAL_W-1:0] cfg_data
);

    cfg_t cfg_reg, cfg_next;

    // State memory port
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    voice_word_t   rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    voice_word_t   wr_data;

    // Divider port
    logic               div_start;
    logic [2*VAL_W-1:0] div_num;
    logic [VAL_W-1:0]   div_den;
    logic               div_done;
    logic [VAL_W-1:0]   div_quo;

    // Register file: indexes past the last register are ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_ATTACK_LEVEL:  cfg_next.attack_level  = cfg_data;
                CFG_ATTACK_TIME:   cfg_next.attack_time   = cfg_data;
                CFG_DECAY_TIME:    cfg_next.decay_time    = cfg_data;
                CFG_SUSTAIN_LEVEL: cfg_next.sustain_level = cfg_data;
                CFG_RELEASE_TIME:  cfg_next.release_time  = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attack_level  <= ATTACK_LEVEL_RST;
            cfg_reg.attack_time   <= ATTACK_TIME_RST;
            cfg_reg.decay_time    <= DECAY_TIME_RST;
            cfg_reg.sustain_level <= SUSTAIN_LEVEL_RST;
            cfg_reg.release_time  <= RELEASE_TIME_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    adsr_state_mem #(
        .VOICES (VOICES)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    adsr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    adsr_seq #(
        .VOICES (VOICES)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .cfg          (cfg_reg),
        .result_valid (result_valid),
        .result       (result),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .div_start    (div_start),
        .div_num      (div_num),
        .div_den      (div_den),
        .div_done     (div_done),
        .div_quo      (div_quo)
    );

endmodule
